// ===== sv/hsl2rgb_pkg.sv =====
// shared types and constants for the hsl to rgb converter
package hsl2rgb_pkg;

  localparam int FIELD_W = 17;
  localparam int BYTE_W  = 8;

  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  // segment of the hue ramp a channel falls into
  typedef enum logic [1:0] {
    RAMP_RISE,
    RAMP_HIGH,
    RAMP_FALL,
    RAMP_LOW
  } ramp_e;

  // hue offset applied per channel
  typedef enum logic [1:0] {
    SHIFT_PLUS_THIRD,
    SHIFT_NONE,
    SHIFT_MINUS_THIRD
  } shift_e;

endpackage

// ===== sv/hsl2rgb_channel.sv =====
// one color channel: hue ramp, blend between p and q, byte scaling
module hsl2rgb_channel
  import hsl2rgb_pkg::*;
#(
  parameter int     FRACTION_BITS = 16,
  parameter shift_e HUE_SHIFT     = SHIFT_NONE
) (
  input  logic                     clk_i,
  input  logic [FRACTION_BITS:0]   hue_i,
  input  logic [FRACTION_BITS:0]   lo_i,
  input  logic [FRACTION_BITS:0]   hi_i,
  input  logic [FRACTION_BITS:0]   span_i,
  input  logic                     gray_i,
  input  logic [FRACTION_BITS:0]   light_i,
  output logic [BYTE_W-1:0]        byte_o
);

  localparam int VW = FRACTION_BITS + 1;
  localparam logic [VW:0]   ONE_X   = (VW+1)'(1) << FRACTION_BITS;
  localparam logic [VW+2:0] ONE_W   = (VW+3)'(1) << FRACTION_BITS;
  localparam logic [VW:0]   THIRD_X = (VW+1)'((1 << FRACTION_BITS) / 3);

  // stage b: wrapped hue, segment and ramp factor
  logic [VW:0]   t_x;
  logic [VW+2:0] t6;
  ramp_e         region_d, region_b_q, region_c_q, region_d_q;
  logic [VW-1:0] factor_d, factor_b_q, factor_c_q;

  always_comb begin
    unique case (HUE_SHIFT)
      SHIFT_PLUS_THIRD: begin
        t_x = {1'b0, hue_i} + THIRD_X;
        if (t_x > ONE_X) begin
          t_x = t_x - ONE_X;
        end
      end
      SHIFT_MINUS_THIRD: begin
        if ({1'b0, hue_i} < THIRD_X) begin
          t_x = {1'b0, hue_i} + ONE_X - THIRD_X;
        end else begin
          t_x = {1'b0, hue_i} - THIRD_X;
        end
      end
      default: t_x = {1'b0, hue_i};
    endcase
    t6 = ((VW+3)'(t_x) << 2) + ((VW+3)'(t_x) << 1);
    // 2t < one and 3t < 2*one tested on 6t against 3*one and 4*one
    if (t6 < ONE_W) begin
      region_d = RAMP_RISE;
      factor_d = VW'(t6);
    end else if (t6 < (ONE_W << 1) + ONE_W) begin
      region_d = RAMP_HIGH;
      factor_d = '0;
    end else if (t6 < (ONE_W << 2)) begin
      region_d = RAMP_FALL;
      factor_d = VW'((ONE_W << 2) - t6);
    end else begin
      region_d = RAMP_LOW;
      factor_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    region_b_q <= region_d;
    factor_b_q <= factor_d;
    region_c_q <= region_b_q;
    factor_c_q <= factor_b_q;
  end

  // stage d: span times ramp factor
  logic [2*VW-1:0] prod;
  logic [VW-1:0]   blend_d, blend_q, lo_d_q, hi_d_q, light_d_q;
  logic            gray_d_q;

  assign prod    = span_i * factor_c_q;
  assign blend_d = prod[FRACTION_BITS +: VW];

  always_ff @(posedge clk_i) begin
    blend_q    <= blend_d;
    region_d_q <= region_c_q;
    lo_d_q     <= lo_i;
    hi_d_q     <= hi_i;
    gray_d_q   <= gray_i;
    light_d_q  <= light_i;
  end

  // stage e: channel value
  logic [VW:0]   sum;
  logic [VW-1:0] value_d, value_q;

  always_comb begin
    sum = {1'b0, lo_d_q} + {1'b0, blend_q};
    if (gray_d_q) begin
      value_d = light_d_q;
    end else begin
      case (region_d_q) inside
        RAMP_RISE, RAMP_FALL: value_d = VW'(sum);
        RAMP_HIGH:            value_d = hi_d_q;
        default:              value_d = lo_d_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // stage f: scale by 255, truncate, saturate
  logic [VW+7:0] scaled;
  logic [8:0]    whole;
  logic [BYTE_W-1:0] byte_d, byte_q;

  always_comb begin
    scaled = ((VW+8)'(value_q) << 8) - (VW+8)'(value_q);
    whole  = scaled[FRACTION_BITS +: 9];
    byte_d = whole[8] ? {BYTE_W{1'b1}} : whole[BYTE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== sv/hsl_to_rgb_converter.sv =====
// hsl to rgb color converter, fixed point, one pixel per clock
//
//   channel   direction  ports                      handshake
//   command   in         start, busy, hsl_i         start high while busy low
//   result    out        result_o, result_strobe_o  strobe for one cycle
//
// one transaction is taken every clock cycle; busy stays low
// the result strobe follows the accepting edge through six register stages (clamp,
// l*s multiply, q/p, ramp multiply, blend, byte scaling)
// reset clears only the valid bits; results appear for exactly one cycle
// the receiver cannot hold results off, so the pipeline never stalls
module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  hsl_t  hsl_i,
  output rgb_t  result_o,
  output logic  result_strobe_o
);

  localparam int VW = FRACTION_BITS + 1;
  localparam int IW = (VW > FIELD_W) ? VW : FIELD_W;
  localparam logic [IW-1:0] ONE_I = IW'(1) << FRACTION_BITS;
  localparam logic [VW:0]   ONE_X = (VW+1)'(1) << FRACTION_BITS;

  assign busy = 1'b0;

  // valid bits along the pipeline
  logic [5:0] valid_d, valid_q;

  assign valid_d = {valid_q[4:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage a: clamp inputs to one
  logic [IW-1:0] h_w, s_w, l_w;
  logic [VW-1:0] h_a_d, s_a_d, l_a_d;
  logic [VW-1:0] h_a_q, s_a_q, l_a_q;

  always_comb begin
    h_w   = IW'(hsl_i.hue);
    s_w   = IW'(hsl_i.saturation);
    l_w   = IW'(hsl_i.lightness);
    h_a_d = VW'((h_w > ONE_I) ? ONE_I : h_w);
    s_a_d = VW'((s_w > ONE_I) ? ONE_I : s_w);
    l_a_d = VW'((l_w > ONE_I) ? ONE_I : l_w);
  end

  always_ff @(posedge clk_i) begin
    h_a_q <= h_a_d;
    s_a_q <= s_a_d;
    l_a_q <= l_a_d;
  end

  // stage b: l*s
  logic [2*VW-1:0] ls_full;
  logic [VW-1:0]   ls_b_q, s_b_q, l_b_q;
  logic            gray_b_q;

  assign ls_full = l_a_q * s_a_q;

  always_ff @(posedge clk_i) begin
    ls_b_q   <= ls_full[FRACTION_BITS +: VW];
    s_b_q    <= s_a_q;
    l_b_q    <= l_a_q;
    gray_b_q <= (s_a_q == '0);
  end

  // stage c: q, p and their difference
  logic [VW:0]   l2, q_x;
  logic [VW-1:0] q_c_d, p_c_d;
  logic [VW-1:0] lo_c_q, hi_c_q, span_c_q, l_c_q;
  logic          gray_c_q;

  always_comb begin
    l2 = {l_b_q, 1'b0};
    // l*(1+s) truncated equals l + trunc(l*s)
    if (l2 < ONE_X) begin
      q_x = {1'b0, l_b_q} + {1'b0, ls_b_q};
    end else begin
      q_x = {1'b0, l_b_q} + {1'b0, s_b_q} - {1'b0, ls_b_q};
    end
    q_c_d = VW'(q_x);
    if (l2 < q_x) begin
      p_c_d = '0;
    end else if (l_b_q > q_c_d) begin
      p_c_d = q_c_d;
    end else begin
      p_c_d = VW'(l2 - q_x);
    end
  end

  always_ff @(posedge clk_i) begin
    lo_c_q   <= p_c_d;
    hi_c_q   <= q_c_d;
    span_c_q <= q_c_d - p_c_d;
    l_c_q    <= l_b_q;
    gray_c_q <= gray_b_q;
  end

  // stages b through f per channel
  logic [BYTE_W-1:0] red_f, green_f, blue_f;

  hsl2rgb_channel #(
    .FRACTION_BITS (FRACTION_BITS),
    .HUE_SHIFT     (SHIFT_PLUS_THIRD)
  ) u_red (
    .clk_i   (clk_i),
    .hue_i   (h_a_q),
    .lo_i    (lo_c_q),
    .hi_i    (hi_c_q),
    .span_i  (span_c_q),
    .gray_i  (gray_c_q),
    .light_i (l_c_q),
    .byte_o  (red_f)
  );

  hsl2rgb_channel #(
    .FRACTION_BITS (FRACTION_BITS),
    .HUE_SHIFT     (SHIFT_NONE)
  ) u_green (
    .clk_i   (clk_i),
    .hue_i   (h_a_q),
    .lo_i    (lo_c_q),
    .hi_i    (hi_c_q),
    .span_i  (span_c_q),
    .gray_i  (gray_c_q),
    .light_i (l_c_q),
    .byte_o  (green_f)
  );

  hsl2rgb_channel #(
    .FRACTION_BITS (FRACTION_BITS),
    .HUE_SHIFT     (SHIFT_MINUS_THIRD)
  ) u_blue (
    .clk_i   (clk_i),
    .hue_i   (h_a_q),
    .lo_i    (lo_c_q),
    .hi_i    (hi_c_q),
    .span_i  (span_c_q),
    .gray_i  (gray_c_q),
    .light_i (l_c_q),
    .byte_o  (blue_f)
  );

  assign result_o.red    = red_f;
  assign result_o.green  = green_f;
  assign result_o.blue   = blue_f;
  assign result_strobe_o = valid_q[5];

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the hsl to rgb converter
`timescale 1ns / 100ps

module tb
  import hsl2rgb_pkg::*;
();

  localparam int FB = 16;
  localparam longint unsigned UNIT = 64'd1 << FB;
  localparam longint UNIT_S = 64'sd1 << FB;
  localparam int RANDOM_PIXELS = 1450;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    hsl_t px;
    bit   known;
    rgb_t rgb;
  } pixel_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  hsl_t hsl_i;
  rgb_t result_o;
  logic result_strobe_o;

  // tag travelling with the pixel on the bus: typed-in expectation, if any
  logic px_known;
  rgb_t px_rgb;

  rgb_t rgb_pending[$];
  int   err_cnt;
  int   idle_cycles;
  int   burst_left;

  hsl_to_rgb_converter #(.FRACTION_BITS(FB)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .hsl_i          (hsl_i),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint unsigned clamp_unit(logic [FIELD_W-1:0] v);
    longint unsigned x;
    x = v;
    return (x > UNIT) ? UNIT : x;
  endfunction

  function automatic logic [BYTE_W-1:0] scale_byte(longint unsigned v);
    longint unsigned b;
    b = (v * 255) >> FB;
    return (b > 255) ? 8'd255 : b[BYTE_W-1:0];
  endfunction

  // piecewise hue ramp between p and q, t may lie outside the circle
  function automatic longint unsigned hue_ramp(longint unsigned lo, longint unsigned hi,
                                               longint t);
    longint unsigned u;
    longint unsigned d;
    d = hi - lo;
    if (t < 0) t += UNIT_S;
    if (t > UNIT_S) t -= UNIT_S;
    if (t < 0) t = 0;
    u = t;
    if (6 * u < UNIT) return lo + ((d * 6 * u) >> FB);
    if (2 * u < UNIT) return hi;
    if (3 * u < 2 * UNIT) return lo + ((d * (4 * UNIT - 6 * u)) >> FB);
    return lo;
  endfunction

  function automatic rgb_t rgb_of_hsl(hsl_t px);
    longint unsigned h, s, l, q, p, r, g, b;
    longint hs, third;
    rgb_t res;
    h = clamp_unit(px.hue);
    s = clamp_unit(px.saturation);
    l = clamp_unit(px.lightness);
    if (s == 0) begin
      r = l;
      g = l;
      b = l;
    end else begin
      hs = h;
      third = UNIT / 3;
      if (2 * l < UNIT) q = (l * (UNIT + s)) >> FB;
      else q = l + s - ((l * s) >> FB);
      p = (2 * l >= q) ? 2 * l - q : 0;
      if (p > q) p = q;
      r = hue_ramp(p, q, hs + third);
      g = hue_ramp(p, q, hs);
      b = hue_ramp(p, q, hs - third);
    end
    res.red = scale_byte(r);
    res.green = scale_byte(g);
    res.blue = scale_byte(b);
    return res;
  endfunction

  // mostly in-range fractions, some ramp and clamp edges, some raw 17-bit noise
  function automatic logic [FIELD_W-1:0] pick_fraction();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) return FIELD_W'($urandom_range(0, 65536));
    if (mode < 8) begin
      case ($urandom_range(0, 11))
        0: return 17'd0;
        1: return 17'd1;
        2: return 17'd10922;
        3: return 17'd10923;
        4: return 17'd21845;
        5: return 17'd21846;
        6: return 17'd32767;
        7: return 17'd32768;
        8: return 17'd43690;
        9: return 17'd43691;
        10: return 17'd65535;
        default: return 17'd65536;
      endcase
    end
    return FIELD_W'($urandom_range(0, 131071));
  endfunction

  task automatic drive_pixel(hsl_t px, bit known, rgb_t rgb);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(50, 200);
      else burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start <= 1'b1;
    hsl_i <= px;
    px_known <= known;
    px_rgb <= rgb;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // result check, expectation capture and watchdog
  always @(posedge clk_i) begin
    rgb_t exp_rgb;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (result_strobe_o === 1'b1) begin
        moved = 1'b1;
        if (rgb_pending.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                   result_o.red, result_o.green, result_o.blue);
          err_cnt++;
        end else begin
          exp_rgb = rgb_pending.pop_front();
          if (result_o.red !== exp_rgb.red || result_o.green !== exp_rgb.green ||
              result_o.blue !== exp_rgb.blue) begin
            $display("%0t: rgb mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                     $time, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                     result_o.red, result_o.green, result_o.blue);
            err_cnt++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        moved = 1'b1;
        rgb_pending.push_back(px_known ? px_rgb : rgb_of_hsl(hsl_i));
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    pixel_row_t rows[$];
    hsl_t px;
    rgb_t none;
    none = '0;
    rst_ni = 1'b0;
    start = 1'b0;
    hsl_i = '0;
    px_known = 1'b0;
    px_rgb = '0;
    err_cnt = 0;
    idle_cycles = 0;
    burst_left = 0;

    // gray and extremes: expectation readable directly
    rows.push_back('{'{17'd0, 17'd0, 17'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{'{17'd0, 17'd0, 17'd65536}, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{'{17'd12345, 17'd0, 17'd32768}, 1'b1, '{8'd127, 8'd127, 8'd127}});
    rows.push_back('{'{17'd0, 17'd0, 17'h1FFFF}, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{'{17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{'{17'd0, 17'd65536, 17'd32768}, 1'b1, '{8'd255, 8'd0, 8'd0}});
    // hue ramp boundaries, wrap and clamp, both q branches
    rows.push_back('{'{17'd65536, 17'd65536, 17'd32768}, 1'b0, none});
    rows.push_back('{'{17'h1FFFF, 17'd65536, 17'd32768}, 1'b0, none});
    rows.push_back('{'{17'd65535, 17'd65536, 17'd32768}, 1'b0, none});
    rows.push_back('{'{17'd10922, 17'd65536, 17'd32768}, 1'b0, none});
    rows.push_back('{'{17'd10923, 17'd65536, 17'd32768}, 1'b0, none});
    rows.push_back('{'{17'd21845, 17'd65536, 17'd32768}, 1'b0, none});
    rows.push_back('{'{17'd21846, 17'd65536, 17'd32768}, 1'b0, none});
    rows.push_back('{'{17'd32767, 17'd65536, 17'd32767}, 1'b0, none});
    rows.push_back('{'{17'd32768, 17'd65536, 17'd32767}, 1'b0, none});
    rows.push_back('{'{17'd43690, 17'd32768, 17'd16384}, 1'b0, none});
    rows.push_back('{'{17'd43691, 17'd32768, 17'd49152}, 1'b0, none});
    rows.push_back('{'{17'd54613, 17'd1, 17'd1}, 1'b0, none});
    rows.push_back('{'{17'd1, 17'd65535, 17'd65535}, 1'b0, none});
    rows.push_back('{'{17'd5000, 17'h1FFFF, 17'd20000}, 1'b0, none});
    rows.push_back('{'{17'd60000, 17'd40000, 17'h10001}, 1'b0, none});
    rows.push_back('{'{17'h15555, 17'h0AAAA, 17'h0AAAA}, 1'b0, none});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) drive_pixel(rows[i].px, rows[i].known, rows[i].rgb);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      px.hue = pick_fraction();
      px.saturation = pick_fraction();
      px.lightness = pick_fraction();
      drive_pixel(px, 1'b0, none);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
